/* hdl/wvna_pkg.sv */
// ----------------------------------------------------------------------------
// Welded vertex normal accumulator package
// Command codes, field widths and default sizes shared by the block.
// ----------------------------------------------------------------------------
package wvna_pkg;

  localparam int unsigned CMD_BITS         = 2;
  localparam int unsigned IDX_BITS         = 10;
  localparam int unsigned NORM_BITS        = 16;
  localparam int unsigned ACC_BITS         = 56;
  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF   = 20;
  localparam logic signed [NORM_BITS-1:0] NORM_ONE = 16'sd32767;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_FACE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

endpackage

/* hdl/welded_vertex_normal_accumulator.sv */
// ----------------------------------------------------------------------------
// Welded vertex normal accumulator
// Loads vertices with position welding, sums area-weighted face normals per
// representative vertex and returns normalised Q1.15 vertex normals.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers at a rising edge with start_i high and busy_o low.
//   busy_o stays high until the command is finished; nothing else is taken.
//   Load walks the stored positions through the one read port of the
//   position memory. Add face does position fetches, six products on the
//   shared multiplier and three read-modify-write passes on the sum memory;
//   it ends after the corner check when a corner is not loaded. Read does
//   a magnitude shift (one bit a cycle), three squares on the shared
//   multiplier, a 32-step square root and three 17-step divisions.
//   Only read returns a result: valid_o is high for one cycle with norm_*_o
//   and status_o. The receiver cannot stall; the result is simply taken.
//   Reset empties the vertex store at once; no clearing pass is needed, as
//   each sum entry is zeroed when its vertex is loaded.
// ----------------------------------------------------------------------------
module welded_vertex_normal_accumulator #(
  parameter int unsigned MAX_VERTICES = wvna_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = wvna_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [wvna_pkg::CMD_BITS-1:0]        command_i,
  input  logic signed [COORD_BITS-1:0]         pos_x_i,
  input  logic signed [COORD_BITS-1:0]         pos_y_i,
  input  logic signed [COORD_BITS-1:0]         pos_z_i,
  input  logic [wvna_pkg::IDX_BITS-1:0]        corner_a_i,
  input  logic [wvna_pkg::IDX_BITS-1:0]        corner_b_i,
  input  logic [wvna_pkg::IDX_BITS-1:0]        corner_c_i,
  input  logic [wvna_pkg::IDX_BITS-1:0]        vertex_index_i,
  output logic                                 busy_o,
  output logic                                 valid_o,
  output logic signed [wvna_pkg::NORM_BITS-1:0] norm_x_o,
  output logic signed [wvna_pkg::NORM_BITS-1:0] norm_y_o,
  output logic signed [wvna_pkg::NORM_BITS-1:0] norm_z_o,
  output logic                                 status_o
);
  import wvna_pkg::*;

  localparam int unsigned IW   = $clog2(MAX_VERTICES);
  localparam int unsigned CNTW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned XW   = (CNTW > IDX_BITS) ? CNTW : IDX_BITS;
  localparam int unsigned PW   = 3 * COORD_BITS;
  localparam int unsigned DW   = COORD_BITS + 1;
  localparam int unsigned SW   = 3 * ACC_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH, S_LWR,
    S_FCHK, S_FB, S_FC, S_FD, S_CROSS, S_CREP, S_CSUM, S_CUPD,
    S_RCHK, S_RREP, S_RSUM, S_SHIFT, S_SQ, S_SQRT, S_DLEN, S_DINI, S_DIV
  } state_e;

  state_e                       state_q;
  logic [PW-1:0]                pkt_q;
  logic [IDX_BITS-1:0]          corner_q [3];
  logic [IDX_BITS-1:0]          vidx_q;
  logic [CNTW-1:0]              count_q;
  logic [CNTW-1:0]              i_q;
  logic                         pend_q;
  logic [IW-1:0]                pidx_q;
  logic [IW-1:0]                rep_q;
  logic [5:0]                   step_q;
  logic [1:0]                   k_q;
  logic [PW-1:0]                pa_q, pb_q;
  logic signed [DW-1:0]         e1_q [3];
  logic signed [DW-1:0]         e2_q [3];
  logic signed [ACC_BITS-1:0]   n_q [3];
  logic signed [63:0]           prod_q;
  logic                         neg_q [3];
  logic [ACC_BITS-1:0]          m_q [3];
  logic [63:0]                  sq_q, root_q, bit_q;
  logic [31:0]                  len_q;
  logic [47:0]                  rem_q;
  logic [16:0]                  quo_q;
  logic signed [NORM_BITS-1:0]  nrm_q [3];
  logic                         status_q, valid_q;

  logic [PW-1:0]                pos_mem [MAX_VERTICES];
  logic [IW-1:0]                rep_mem [MAX_VERTICES];
  logic [SW-1:0]                sum_mem [MAX_VERTICES];
  logic [PW-1:0]                pos_rd_q;
  logic [IW-1:0]                rep_rd_q;
  logic [SW-1:0]                sum_rd_q;

  logic [IW-1:0]                pos_ra, rep_ra, sum_ra, sum_wa;
  logic                         pos_we, rep_we, sum_we;
  logic [SW-1:0]                sum_wd;
  logic signed [31:0]           mul_a, mul_b;
  logic signed [ACC_BITS-1:0]   sum_d [3];
  logic [47:0]                  dsr;
  logic                         ge;
  logic [16:0]                  quo_d;
  logic [15:0]                  qc;
  logic [63:0]                  trial;

  function automatic logic [IW-1:0] to_idx(input logic [IDX_BITS-1:0] c);
    logic [XW-1:0] w;
    w = XW'(c);
    return w[IW-1:0];
  endfunction

  function automatic logic in_range(input logic [IDX_BITS-1:0] c, input logic [CNTW-1:0] n);
    return XW'(c) < XW'(n);
  endfunction

  function automatic logic signed [DW-1:0] coord(input logic [PW-1:0] p, input int unsigned k);
    logic signed [COORD_BITS-1:0] v;
    v = $signed(p[k*COORD_BITS +: COORD_BITS]);
    return DW'(v);
  endfunction

  function automatic logic signed [ACC_BITS-1:0] sat_add(input logic signed [ACC_BITS-1:0] a,
                                                         input logic signed [ACC_BITS-1:0] b);
    logic [ACC_BITS:0] s;
    s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      return s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end
    return $signed(s[ACC_BITS-1:0]);
  endfunction

  assign busy_o   = (state_q != S_IDLE);
  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign norm_x_o = nrm_q[0];
  assign norm_y_o = nrm_q[1];
  assign norm_z_o = nrm_q[2];

  always_comb begin
    pos_ra = '0;
    rep_ra = '0;
    sum_ra = '0;
    sum_wa = rep_q;
    pos_we = 1'b0;
    rep_we = 1'b0;
    sum_we = 1'b0;
    sum_wd = '0;
    case (state_q)
      S_SRCH: pos_ra = i_q[IW-1:0];
      S_FCHK: pos_ra = to_idx(corner_q[0]);
      S_FB:   pos_ra = to_idx(corner_q[1]);
      S_FC:   pos_ra = to_idx(corner_q[2]);
      S_LWR: begin
        pos_we = 1'b1;
        rep_we = 1'b1;
        sum_we = 1'b1;
        sum_wa = count_q[IW-1:0];
      end
      S_CREP: rep_ra = to_idx(corner_q[k_q]);
      S_CSUM: sum_ra = rep_rd_q;
      S_CUPD: begin
        sum_we = 1'b1;
        sum_wd = {sum_d[2], sum_d[1], sum_d[0]};
      end
      S_RCHK: rep_ra = to_idx(vidx_q);
      S_RREP: sum_ra = rep_rd_q;
      default: ;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = sat_add($signed(sum_rd_q[k*ACC_BITS +: ACC_BITS]), n_q[k]);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_CROSS) begin
      case (step_q)
        6'd0: begin mul_a = 32'(e1_q[1]); mul_b = 32'(e2_q[2]); end
        6'd1: begin mul_a = 32'(e1_q[2]); mul_b = 32'(e2_q[1]); end
        6'd2: begin mul_a = 32'(e1_q[2]); mul_b = 32'(e2_q[0]); end
        6'd3: begin mul_a = 32'(e1_q[0]); mul_b = 32'(e2_q[2]); end
        6'd4: begin mul_a = 32'(e1_q[0]); mul_b = 32'(e2_q[1]); end
        6'd5: begin mul_a = 32'(e1_q[1]); mul_b = 32'(e2_q[0]); end
        default: ;
      endcase
    end else if (state_q == S_SQ) begin
      case (step_q)
        6'd0: begin mul_a = $signed({2'b00, m_q[0][29:0]}); mul_b = mul_a; end
        6'd1: begin mul_a = $signed({2'b00, m_q[1][29:0]}); mul_b = mul_a; end
        6'd2: begin mul_a = $signed({2'b00, m_q[2][29:0]}); mul_b = mul_a; end
        default: ;
      endcase
    end
  end

  assign trial = root_q + bit_q;
  assign dsr   = 48'(len_q) << step_q;
  assign ge    = (rem_q >= dsr);
  assign quo_d = quo_q | (17'(ge) << step_q);
  assign qc    = (quo_d > 17'd32767) ? 16'd32767 : quo_d[15:0];

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[count_q[IW-1:0]] <= pkt_q;
    if (rep_we) rep_mem[count_q[IW-1:0]] <= rep_q;
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    pos_rd_q <= pos_mem[pos_ra];
    rep_rd_q <= rep_mem[rep_ra];
    sum_rd_q <= sum_mem[sum_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      valid_q  <= 1'b0;
      status_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      prod_q  <= mul_a * mul_b;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            pkt_q       <= {pos_z_i, pos_y_i, pos_x_i};
            corner_q[0] <= corner_a_i;
            corner_q[1] <= corner_b_i;
            corner_q[2] <= corner_c_i;
            vidx_q      <= vertex_index_i;
            i_q         <= '0;
            pend_q      <= 1'b0;
            case (cmd_e'(command_i))
              CMD_CLEAR: count_q <= '0;
              CMD_LOAD:  if (count_q != CNTW'(MAX_VERTICES)) state_q <= S_SRCH;
              CMD_FACE:  state_q <= S_FCHK;
              CMD_READ:  state_q <= S_RCHK;
              default:   ;
            endcase
          end
        end
        S_SRCH: begin
          if (pend_q && pos_rd_q == pkt_q) begin
            rep_q   <= pidx_q;
            state_q <= S_LWR;
          end else if (i_q == count_q) begin
            rep_q   <= count_q[IW-1:0];
            state_q <= S_LWR;
          end else begin
            pend_q <= 1'b1;
            pidx_q <= i_q[IW-1:0];
            i_q    <= i_q + 1'b1;
          end
        end
        S_LWR: begin
          count_q <= count_q + 1'b1;
          state_q <= S_IDLE;
        end
        S_FCHK: begin
          if (in_range(corner_q[0], count_q) && in_range(corner_q[1], count_q) &&
              in_range(corner_q[2], count_q)) begin
            state_q <= S_FB;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FB: begin
          pa_q    <= pos_rd_q;
          state_q <= S_FC;
        end
        S_FC: begin
          pb_q    <= pos_rd_q;
          state_q <= S_FD;
        end
        S_FD: begin
          for (int k = 0; k < 3; k++) begin
            e1_q[k] <= coord(pb_q, k) - coord(pa_q, k);
            e2_q[k] <= coord(pos_rd_q, k) - coord(pa_q, k);
          end
          step_q  <= '0;
          state_q <= S_CROSS;
        end
        S_CROSS: begin
          if (step_q != 6'd0) begin
            if (!step_q[0]) n_q[step_q[2:1] - 2'd1] <= n_q[step_q[2:1] - 2'd1] -
                                                     ACC_BITS'(prod_q);
            else            n_q[step_q[2:1]] <= ACC_BITS'(prod_q);
          end
          step_q <= step_q + 1'b1;
          if (step_q == 6'd6) begin
            k_q     <= '0;
            state_q <= S_CREP;
          end
        end
        S_CREP: state_q <= S_CSUM;
        S_CSUM: begin
          rep_q   <= rep_rd_q;
          state_q <= S_CUPD;
        end
        S_CUPD: begin
          k_q     <= k_q + 1'b1;
          state_q <= (k_q == 2'd2) ? S_IDLE : S_CREP;
        end
        S_RCHK: begin
          if (in_range(vidx_q, count_q)) begin
            state_q <= S_RREP;
          end else begin
            nrm_q[0] <= '0;
            nrm_q[1] <= '0;
            nrm_q[2] <= NORM_ONE;
            status_q <= 1'b1;
            valid_q  <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        S_RREP: state_q <= S_RSUM;
        S_RSUM: begin
          for (int k = 0; k < 3; k++) begin
            neg_q[k] <= sum_rd_q[k*ACC_BITS + ACC_BITS - 1];
            m_q[k]   <= sum_rd_q[k*ACC_BITS + ACC_BITS - 1] ?
                        (~sum_rd_q[k*ACC_BITS +: ACC_BITS] + 1'b1) :
                        sum_rd_q[k*ACC_BITS +: ACC_BITS];
          end
          if (sum_rd_q == '0) begin
            nrm_q[0] <= '0;
            nrm_q[1] <= '0;
            nrm_q[2] <= NORM_ONE;
            status_q <= 1'b0;
            valid_q  <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if ((m_q[0][ACC_BITS-1:30] | m_q[1][ACC_BITS-1:30] | m_q[2][ACC_BITS-1:30]) != '0)
          begin
            for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
          end else begin
            sq_q    <= '0;
            step_q  <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (step_q != 6'd0) sq_q <= sq_q + 64'(prod_q);
          step_q <= step_q + 1'b1;
          if (step_q == 6'd3) begin
            root_q  <= '0;
            bit_q   <= 64'd1 << 62;
            step_q  <= '0;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_q >= trial) begin
            sq_q   <= sq_q - trial;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q  <= bit_q >> 2;
          step_q <= step_q + 1'b1;
          if (step_q == 6'd31) state_q <= S_DLEN;
        end
        S_DLEN: begin
          len_q   <= (root_q == '0) ? 32'd1 : root_q[31:0];
          k_q     <= '0;
          state_q <= S_DINI;
        end
        S_DINI: begin
          rem_q   <= (48'(m_q[k_q][29:0]) << 15) + 48'(len_q >> 1);
          quo_q   <= '0;
          step_q  <= 6'd16;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (ge) rem_q <= rem_q - dsr;
          quo_q  <= quo_d;
          step_q <= step_q - 1'b1;
          if (step_q == 6'd0) begin
            nrm_q[k_q] <= neg_q[k_q] ? -$signed(qc) : $signed(qc);
            k_q        <= k_q + 1'b1;
            if (k_q == 2'd2) begin
              status_q <= 1'b0;
              valid_q  <= 1'b1;
              state_q  <= S_IDLE;
            end else begin
              state_q <= S_DINI;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for more than one cycle");

  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i != CMD_READ) |=> !valid_o)
    else $error("result after a command that returns none");

  a_unloaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o) |-> (norm_x_o == 0 && norm_y_o == 0 && norm_z_o == NORM_ONE))
    else $error("unloaded read with a normal other than +z");

  a_load_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LWR) |=> (count_q == $past(count_q) + 1'b1))
    else $error("load did not advance the vertex count");
`endif

endmodule
